### rtl/core/amdfs_pkg.sv
// ----------------------------------------------------------------------------
// amdfs_pkg
// Shared types and constants for the adjacency-matrix depth-first order unit.
// ----------------------------------------------------------------------------
package amdfs_pkg;

    localparam int VERTEX_W   = 5;
    localparam int COUNT_W    = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // function codes of a request
    localparam logic [1:0] FUNC_ADD_EDGE = 2'd0;
    localparam logic [1:0] FUNC_CLEAR    = 2'd1;
    localparam logic [1:0] FUNC_TRAVERSE = 2'd2;

    localparam logic [15:0] NO_EDGE_WEIGHT = 16'hFFFF;

    // register index, taken from paddr[2]
    localparam logic REG_VERTEX_COUNT  = 1'b0;
    localparam logic REG_DIRECTED_MODE = 1'b1;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 6'd32;

    typedef struct packed {
        logic [1:0]          func;
        logic [VERTEX_W-1:0] from_vertex;
        logic [VERTEX_W-1:0] to_vertex;
        logic [15:0]         edge_weight;
    } t_in_item;

    typedef struct packed {
        logic [VERTEX_W-1:0] visited_vertex;
        logic                last_of_walk;
    } t_out_item;

    typedef struct packed {
        logic ld_item;
        logic clr_matrix;
        logic rd_from;
        logic wr_from;
        logic rd_to;
        logic wr_to;
        logic trav_init;
        logic start_skip;
        logic start_visit;
        logic push;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] in_func;
        logic       edge_ok;
        logic       undirected;
        logic       start_end;
        logic       start_seen;
        logic       have_cand;
        logic       depth_one;
        logic       out_free;
    } t_dp_status;

endpackage

### rtl/core/amdfs_ram.sv
// ----------------------------------------------------------------------------
// amdfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amdfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/amdfs_ctrl.sv
// ----------------------------------------------------------------------------
// amdfs_ctrl
// Sequencer for edge updates, matrix clear and the depth-first walk.
// ----------------------------------------------------------------------------
module amdfs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  amdfs_pkg::t_dp_status i_status,
    output amdfs_pkg::t_dp_cmd    o_cmd
);
    import amdfs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE       = 6'b000001,
        S_EDGE_FROM  = 6'b000010,
        S_EDGE_TO_RD = 6'b000100,
        S_EDGE_TO_WR = 6'b001000,
        S_START      = 6'b010000,
        S_SCAN       = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    unique case (i_status.in_func)
                        FUNC_ADD_EDGE: begin
                            if (i_status.edge_ok) begin
                                o_cmd.rd_from = 1'b1;
                                n_state       = S_EDGE_FROM;
                            end
                        end
                        FUNC_CLEAR: begin
                            o_cmd.clr_matrix = 1'b1;
                        end
                        FUNC_TRAVERSE: begin
                            o_cmd.trav_init = 1'b1;
                            n_state         = S_START;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EDGE_FROM: begin
                o_cmd.wr_from = 1'b1;
                n_state = i_status.undirected ? S_EDGE_TO_RD : S_IDLE;
            end
            S_EDGE_TO_RD: begin
                o_cmd.rd_to = 1'b1;
                n_state     = S_EDGE_TO_WR;
            end
            S_EDGE_TO_WR: begin
                o_cmd.wr_to = 1'b1;
                n_state     = S_IDLE;
            end
            S_START: begin
                if (i_status.start_end) begin
                    n_state = S_IDLE;
                end else if (i_status.start_seen) begin
                    o_cmd.start_skip = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.start_visit = 1'b1;
                    n_state           = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.have_cand) begin
                    // hold until the output slot frees up
                    o_cmd.push = i_status.out_free;
                end else begin
                    o_cmd.pop = 1'b1;
                    if (i_status.depth_one) begin
                        n_state = S_START;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### rtl/core/amdfs_datapath.sv
// ----------------------------------------------------------------------------
// amdfs_datapath
// Adjacency matrix RAM, visited mask, walk stack and result register.
// ----------------------------------------------------------------------------
module amdfs_datapath #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  amdfs_pkg::t_in_item               i_in_item,
    input  logic [amdfs_pkg::COUNT_W-1:0]     i_vertex_count,
    input  logic                              i_directed_mode,
    input  amdfs_pkg::t_dp_cmd                i_cmd,
    output amdfs_pkg::t_dp_status             o_status,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output amdfs_pkg::t_out_item              o_out_item
);
    import amdfs_pkg::*;

    // vertex indices are 5 bits wide, so at most 32 rows are reachable
    localparam int NV = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int IW = $clog2(NV);
    localparam int CW = $clog2(NV + 1);

    t_in_item        r_item;
    logic [NV-1:0]   r_row_valid;
    logic            r_rd_valid;
    logic [NV-1:0]   r_visited;
    logic [IW-1:0]   r_stack [NV];
    logic [CW-1:0]   r_depth;
    logic [CW-1:0]   r_start;
    logic [CW-1:0]   r_emit;
    logic            r_out_valid;
    t_out_item       r_out_item;

    logic [CW-1:0]   eff_count;
    logic [NV-1:0]   count_mask;
    logic [NV-1:0]   row_bits;
    logic [NV-1:0]   cand_bits;
    logic [NV-1:0]   cand_low;
    logic [IW-1:0]   cand_idx;
    logic [IW-1:0]   start_idx;
    logic [CW-1:0]   depth_m2;
    logic [IW-1:0]   pop_idx;
    logic [IW-1:0]   emit_idx;
    logic            emit;
    logic            present;
    logic [NV-1:0]   vertex_bit;
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [NV-1:0]   ram_wdata;
    logic            ram_re;
    logic [IW-1:0]   ram_raddr;
    logic [NV-1:0]   ram_rdata;

    always_comb begin
        if (int'(i_vertex_count) > NV) begin
            eff_count = CW'(NV);
        end else begin
            eff_count = CW'(i_vertex_count);
        end
        for (int i = 0; i < NV; i++) begin
            count_mask[i] = (i < int'(eff_count));
        end
    end

    // unwritten rows read as empty
    assign row_bits  = r_rd_valid ? ram_rdata : '0;
    assign cand_bits = row_bits & ~r_visited & count_mask;
    assign cand_low  = cand_bits & (~cand_bits + NV'(1));

    always_comb begin
        cand_idx = '0;
        for (int i = 0; i < NV; i++) begin
            if (cand_low[i]) begin
                cand_idx = cand_idx | IW'(i);
            end
        end
    end

    assign start_idx = r_start[IW-1:0];
    assign depth_m2  = r_depth - CW'(2);
    assign pop_idx   = depth_m2[IW-1:0];
    assign emit      = i_cmd.start_visit || i_cmd.push;
    assign emit_idx  = i_cmd.start_visit ? start_idx : cand_idx;

    // edge row update
    assign present = (r_item.edge_weight != NO_EDGE_WEIGHT);
    always_comb begin
        if (i_cmd.wr_to) begin
            ram_waddr  = r_item.to_vertex[IW-1:0];
            vertex_bit = NV'(1) << r_item.from_vertex[IW-1:0];
        end else begin
            ram_waddr  = r_item.from_vertex[IW-1:0];
            vertex_bit = NV'(1) << r_item.to_vertex[IW-1:0];
        end
        ram_wdata = present ? (row_bits | vertex_bit) : (row_bits & ~vertex_bit);
    end
    assign ram_we = i_cmd.wr_from || i_cmd.wr_to;

    always_comb begin
        ram_re = i_cmd.rd_from || i_cmd.rd_to || emit || (i_cmd.pop && !o_status.depth_one);
        if (i_cmd.rd_from) begin
            ram_raddr = i_in_item.from_vertex[IW-1:0];
        end else if (i_cmd.rd_to) begin
            ram_raddr = r_item.to_vertex[IW-1:0];
        end else if (i_cmd.start_visit) begin
            ram_raddr = start_idx;
        end else if (i_cmd.push) begin
            ram_raddr = cand_idx;
        end else begin
            ram_raddr = r_stack[pop_idx];
        end
    end

    amdfs_ram #(
        .WIDTH (NV),
        .DEPTH (NV)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_status            = '0;
        o_status.in_func    = i_in_item.func;
        o_status.edge_ok    = ({1'b0, i_in_item.from_vertex} < 6'(NV))
                           && ({1'b0, i_in_item.to_vertex} < 6'(NV));
        o_status.undirected = !i_directed_mode;
        o_status.start_end  = (r_start == eff_count);
        o_status.start_seen = r_visited[start_idx];
        o_status.have_cand  = |cand_bits;
        o_status.depth_one  = (r_depth == CW'(1));
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
            r_visited   <= '0;
            r_depth     <= '0;
            r_start     <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_matrix) begin
                r_row_valid <= '0;
            end else if (ram_we) begin
                r_row_valid[ram_waddr] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_valid <= r_row_valid[ram_raddr];
            end
            if (i_cmd.trav_init) begin
                r_visited <= '0;
                r_depth   <= '0;
                r_start   <= '0;
                r_emit    <= '0;
            end
            if (i_cmd.start_skip) begin
                r_start <= r_start + CW'(1);
            end
            if (i_cmd.start_visit) begin
                r_visited[start_idx] <= 1'b1;
                r_depth              <= CW'(1);
            end
            if (i_cmd.push) begin
                r_visited[cand_idx] <= 1'b1;
                r_depth             <= r_depth + CW'(1);
            end
            if (i_cmd.pop) begin
                r_depth <= r_depth - CW'(1);
            end
            if (emit) begin
                r_emit <= r_emit + CW'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.start_visit) begin
            r_stack[0] <= start_idx;
        end
        if (i_cmd.push) begin
            r_stack[r_depth[IW-1:0]] <= cand_idx;
        end
        if (emit) begin
            r_out_item.visited_vertex <= VERTEX_W'(emit_idx);
            r_out_item.last_of_walk   <= (r_emit == eff_count - CW'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_push_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> o_status.out_free)
        else $error("push issued while the result register is blocked");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_depth != '0))
        else $error("pop from an empty walk stack");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (r_emit < eff_count))
        else $error("more results than vertices in use");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_out_valid)
        else $error("emitted vertex did not reach the output register");

    a_stack_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != '0) |-> (r_visited != '0))
        else $error("walk stack holds entries while no vertex is visited");
`endif

endmodule

### rtl/core/adjacency_matrix_dfs_order_unit.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_order_unit
// Adjacency bit matrix with edge updates, clear and depth-first vertex order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  ---------------------------
//  in        request    i_in_valid/o_in_ready   i_in_item  (t_in_item)
//  out       result     o_out_valid/i_out_ready o_out_item (t_out_item)
//  config    APB write  psel/penable/pwrite     paddr, pwdata, prdata
//
//  Directed add edge reads and writes the from row, undirected add edge
//  also the to row, clear drops all row valid bits; a traversal makes one
//  start check per vertex in use and, per vertex, one visit and one pop. The
//  single read port of the matrix RAM, one row per cycle while the result
//  register is free, sets the walk rate. Reset (synchronous, i_rst_n low)
//  empties the matrix through its row valid bits. Requests are taken only
//  between operations; a waiting result stalls the walk, not the next request.
//
module adjacency_matrix_dfs_order_unit #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  amdfs_pkg::t_in_item                 i_in_item,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output amdfs_pkg::t_out_item                o_out_item,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [amdfs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [amdfs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [amdfs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import amdfs_pkg::*;

    logic [COUNT_W-1:0] r_vertex_count;
    logic               r_directed_mode;
    logic               cfg_write;
    t_dp_cmd            dp_cmd;
    t_dp_status         dp_status;

    // Zero-wait APB: every access completes in its access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count  <= VERTEX_COUNT_RESET;
            r_directed_mode <= 1'b0;
        end else if (cfg_write) begin
            // paddr[2] selects the register; byte lanes inside a word alias
            if (paddr[2] == REG_VERTEX_COUNT) begin
                r_vertex_count <= pwdata[COUNT_W-1:0];
            end else begin
                r_directed_mode <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_DIRECTED_MODE) begin
            prdata = {{(APB_DATA_W-1){1'b0}}, r_directed_mode};
        end else begin
            prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, r_vertex_count};
        end
    end

    // Controller: decode the request and step the walk one row per cycle while the result register is free.
    amdfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Datapath: matrix RAM, visited mask, stack and the result register.
    amdfs_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_item       (i_in_item),
        .i_vertex_count  (r_vertex_count),
        .i_directed_mode (r_directed_mode),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_out_item      (o_out_item)
    );

endmodule

### dv/tb_adjacency_matrix_dfs_order_unit.sv
// ----------------------------------------------------------------------------
// tb_adjacency_matrix_dfs_order_unit
// Self-checking bench for the adjacency-matrix depth-first order unit.
// Edge, clear and traversal requests are driven on the request channel. A
// local graph model tracks the bit matrix and computes the visiting order of
// every traversal, and the returned vertices are checked in order against it.
// A short directed table comes first, then random phases that vary the
// vertex count, the edge mode and the idling on both channels.
// ----------------------------------------------------------------------------
module tb_adjacency_matrix_dfs_order_unit;

    import amdfs_pkg::*;

    localparam int GRAPH_SIZE      = 32;
    localparam int SETTLE_CYCLES   = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_REQUESTS  = 24;
    localparam int USE_PREDICTOR   = -1;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef enum bit {ROW_REQUEST, ROW_CONFIG} t_row_kind;

    // one line of the directed table: a request or a register write
    typedef struct {
        t_row_kind  kind;
        t_in_item   req;
        int         typed_count;   // expect vertices 0..n-1 in order, or predict
        logic       reg_sel;
        logic [31:0] reg_value;
    } t_directed_row;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_item               i_in_item;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out_item              o_out_item;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // ------------------------------------------------------------------
    // Graph model state and bookkeeping
    // ------------------------------------------------------------------
    logic [GRAPH_SIZE-1:0]  adj_rows [GRAPH_SIZE];
    logic [GRAPH_SIZE-1:0]  visited_mask;
    logic [COUNT_W-1:0]     cfg_vertex_count;
    logic                   cfg_directed;

    t_out_item              walk_result[$];     // order of the latest request
    t_out_item              visit_order_q[$];   // vertices still to come back
    t_directed_row          directed_rows[$];

    int mismatch_count;
    int requests_sent;
    int traversals_sent;
    int vertices_checked;
    int settings_used;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_request;
    int hold_left;
    t_out_item want;

    adjacency_matrix_dfs_order_unit #(.MAX_VERTICES(GRAPH_SIZE)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops results.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Graph model
    // ------------------------------------------------------------------
    function automatic int effective_count();
        return (cfg_vertex_count > GRAPH_SIZE) ? GRAPH_SIZE : int'(cfg_vertex_count);
    endfunction

    function automatic void note_visit(input int v);
        visited_mask[v] = 1'b1;
        walk_result.push_back(t_out_item'{visited_vertex: VERTEX_W'(v), last_of_walk: 1'b0});
    endfunction

    // Apply one request to the model; a traversal leaves its order in walk_result.
    function automatic void predict_request(input t_in_item req);
        logic [VERTEX_W-1:0] path [GRAPH_SIZE];
        int   depth;
        int   n;
        int   top;
        int   nx;
        logic present;
        walk_result.delete();
        case (req.func)
            FUNC_ADD_EDGE: begin
                present = (req.edge_weight != NO_EDGE_WEIGHT);
                adj_rows[req.from_vertex][req.to_vertex] = present;
                if (!cfg_directed) begin
                    adj_rows[req.to_vertex][req.from_vertex] = present;
                end
            end
            FUNC_CLEAR: begin
                for (int r = 0; r < GRAPH_SIZE; r++) begin
                    adj_rows[r] = '0;
                end
            end
            FUNC_TRAVERSE: begin
                n = effective_count();
                visited_mask = '0;
                for (int s = 0; s < n; s++) begin
                    if (!visited_mask[s]) begin
                        note_visit(s);
                        path[0] = VERTEX_W'(s);
                        depth = 1;
                        while (depth > 0) begin
                            top = path[depth-1];
                            // lowest-numbered unvisited neighbor inside the count
                            nx = 0;
                            while (nx < n && !(adj_rows[top][nx] && !visited_mask[nx])) begin
                                nx++;
                            end
                            if (nx < n && depth < GRAPH_SIZE) begin
                                note_visit(nx);
                                path[depth] = VERTEX_W'(nx);
                                depth++;
                            end else begin
                                depth--;
                            end
                        end
                    end
                end
                if (walk_result.size() > 0) begin
                    walk_result[walk_result.size()-1].last_of_walk = 1'b1;
                end
            end
            default: ;  // unused function code: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one request, hold it until taken, then queue what it should return.
    // Valid stays high when the next request follows without a gap.
    task automatic send_request(input t_in_item req, input int typed_count);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);

        predict_request(req);
        requests_sent++;
        if (req.func == FUNC_TRAVERSE) begin
            traversals_sent++;
        end
        if (typed_count == USE_PREDICTOR) begin
            foreach (walk_result[k]) visit_order_q.push_back(walk_result[k]);
        end else begin
            // plain ascending order, last one marked
            for (int v = 0; v < typed_count; v++) begin
                visit_order_q.push_back(t_out_item'{visited_vertex: VERTEX_W'(v),
                                                    last_of_walk: (v == typed_count - 1)});
            end
        end
    endtask

    // Drop valid, wait for every pending vertex, then let a silent request finish.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (visit_order_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value on the access edge.
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (reg_sel == REG_VERTEX_COUNT) begin
            cfg_vertex_count = value[COUNT_W-1:0];
        end else begin
            cfg_directed = value[0];
        end
        settings_used++;
    endtask

    function automatic t_directed_row req_row(input logic [1:0] func,
                                              input logic [VERTEX_W-1:0] a,
                                              input logic [VERTEX_W-1:0] b,
                                              input logic [15:0] weight,
                                              input int typed_count);
        t_directed_row row;
        row.kind        = ROW_REQUEST;
        row.req         = '{func: func, from_vertex: a, to_vertex: b, edge_weight: weight};
        row.typed_count = typed_count;
        row.reg_sel     = REG_VERTEX_COUNT;
        row.reg_value   = '0;
        return row;
    endfunction

    function automatic t_directed_row cfg_row(input logic reg_sel, input logic [31:0] value);
        t_directed_row row;
        row.kind        = ROW_CONFIG;
        row.req         = '0;
        row.typed_count = USE_PREDICTOR;
        row.reg_sel     = reg_sel;
        row.reg_value   = value;
        return row;
    endfunction

    // Random request, mostly edges between vertices that the walk can see.
    function automatic t_in_item random_request();
        t_in_item req;
        int pick;
        int top_vertex;
        pick       = $urandom_range(99);
        top_vertex = (effective_count() > 0) ? effective_count() - 1 : 0;
        req.from_vertex = ($urandom_range(9) == 0) ? VERTEX_W'($urandom_range(31))
                                                   : VERTEX_W'($urandom_range(top_vertex));
        req.to_vertex   = ($urandom_range(9) == 0) ? VERTEX_W'($urandom_range(31))
                                                   : VERTEX_W'($urandom_range(top_vertex));
        req.edge_weight = ($urandom_range(7) == 0) ? NO_EDGE_WEIGHT : 16'($urandom_range(16'hFFFE));
        if (pick < 2) begin
            req.func = FUNC_UNUSED;
        end else if (pick < 5) begin
            req.func = FUNC_CLEAR;
        end else if (pick < 22) begin
            req.func = FUNC_TRAVERSE;
        end else begin
            req.func = FUNC_ADD_EDGE;
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random ready, optional long hold-off, in-order check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (visit_order_q.size() == 0) begin
                $error("visited_vertex: expected none, actual %0d", o_out_item.visited_vertex);
                mismatch_count++;
            end else begin
                want = visit_order_q.pop_front();
                vertices_checked++;
                if (o_out_item.visited_vertex !== want.visited_vertex) begin
                    $error("visited_vertex: expected %0d, actual %0d",
                           want.visited_vertex, o_out_item.visited_vertex);
                    mismatch_count++;
                end
                if (o_out_item.last_of_walk !== want.last_of_walk) begin
                    $error("last_of_walk: expected %0d, actual %0d",
                           want.last_of_walk, o_out_item.last_of_walk);
                    mismatch_count++;
                end
            end
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_ready <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;

        mismatch_count     = 0;
        requests_sent      = 0;
        traversals_sent    = 0;
        vertices_checked   = 0;
        settings_used      = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 0;
        hold_left          = 0;

        // model state after reset: empty matrix, 32 vertices, undirected
        for (int r = 0; r < GRAPH_SIZE; r++) adj_rows[r] = '0;
        visited_mask     = '0;
        cfg_vertex_count = VERTEX_COUNT_RESET;
        cfg_directed     = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. A typed count means vertices 0..n-1 in ascending
        // order, which holds whenever the visible graph has no edges.
        directed_rows.push_back(req_row(FUNC_TRAVERSE, 5'd0, 5'd0, 16'd0, 32));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd0, 5'd31, 16'd0, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd5, 5'd3, 16'd1234, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd3, 5'd17, 16'hFFFE, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd17, 5'd17, 16'd7, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd31, 5'd12, NO_EDGE_WEIGHT,
                                        USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_TRAVERSE, 5'd31, 5'd31, 16'hFFFF, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd5, 5'd3, NO_EDGE_WEIGHT,
                                        USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_UNUSED, 5'd31, 5'd31, 16'hFFFF, 0));
        directed_rows.push_back(req_row(FUNC_TRAVERSE, 5'd0, 5'd0, 16'd0, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_CLEAR, 5'd21, 5'd10, 16'hAAAA, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_TRAVERSE, 5'd0, 5'd0, 16'd0, 32));
        // a zero count walks nothing, a count of one only vertex 0
        directed_rows.push_back(cfg_row(REG_VERTEX_COUNT, 32'd0));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd0, 5'd1, 16'd1, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_TRAVERSE, 5'd0, 5'd0, 16'd0, 0));
        directed_rows.push_back(cfg_row(REG_VERTEX_COUNT, 32'd1));
        directed_rows.push_back(req_row(FUNC_TRAVERSE, 5'd0, 5'd0, 16'd0, 1));
        // directed edges, count above the matrix size saturates
        directed_rows.push_back(cfg_row(REG_DIRECTED_MODE, 32'd1));
        directed_rows.push_back(cfg_row(REG_VERTEX_COUNT, 32'd63));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd31, 5'd30, 16'd9, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd30, 5'd0, 16'd9, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd2, 5'd10, 16'h5555, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd10, 5'd2, NO_EDGE_WEIGHT,
                                        USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_TRAVERSE, 5'd0, 5'd0, 16'd0, USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_ADD_EDGE, 5'd0, 5'd0, NO_EDGE_WEIGHT,
                                        USE_PREDICTOR));
        directed_rows.push_back(req_row(FUNC_TRAVERSE, 5'd0, 5'd0, 16'd0, USE_PREDICTOR));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                wait_quiet();
                write_register(directed_rows[i].reg_sel, directed_rows[i].reg_value);
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].typed_count);
            end
        end

        // Random phases: each changes the setting while quiet, then runs
        // edge batches and walks under its own idling pattern.
        for (int phase = 0; phase < 4; phase++) begin
            int counted;
            t_in_item req;
            wait_quiet();
            case (phase)
                0: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                    write_register(REG_VERTEX_COUNT, 32'd32);
                    write_register(REG_DIRECTED_MODE, 32'd0);
                end
                1: begin
                    sender_idle_pct = 58; receiver_stall_pct = 0;
                    write_register(REG_VERTEX_COUNT, 32'($urandom_range(31, 2)));
                    write_register(REG_DIRECTED_MODE, 32'd1);
                end
                2: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 58;
                    write_register(REG_VERTEX_COUNT, 32'($urandom_range(32, 1)));
                    write_register(REG_DIRECTED_MODE, 32'd0);
                end
                default: begin
                    sender_idle_pct = 29; receiver_stall_pct = 29;
                    write_register(REG_VERTEX_COUNT, 32'd32);
                    write_register(REG_DIRECTED_MODE, 32'($urandom_range(1)));
                end
            endcase

            counted = 0;
            if (phase == 2) begin
                // Hold results off while walks keep coming, so the block
                // backs up and stops taking requests.
                hold_request = HOLD_OFF_CYCLES;
                for (int k = 0; k < 4; k++) begin
                    req = random_request();
                    req.func = FUNC_TRAVERSE;
                    send_request(req, USE_PREDICTOR);
                    counted++;
                end
            end
            while (counted < PHASE_REQUESTS) begin
                req = random_request();
                send_request(req, USE_PREDICTOR);
                if (req.func != FUNC_UNUSED) begin
                    counted++;
                end
            end
        end

        wait_quiet();

        $display("covered %0d requests (%0d traversals), %0d settings written",
                 requests_sent, traversals_sent, settings_used);
        $display("checked %0d visited vertices with all idle and stall patterns",
                 vertices_checked);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### adjacency_matrix_dfs_order_unit.f
rtl/core/amdfs_pkg.sv
rtl/core/amdfs_ram.sv
rtl/core/amdfs_ctrl.sv
rtl/core/amdfs_datapath.sv
rtl/core/adjacency_matrix_dfs_order_unit.sv
dv/tb_adjacency_matrix_dfs_order_unit.sv
